>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the slice partition RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sps_pkg.sv
// Package for the slice partition and block statistics block.
// Holds field widths, codes, payload structs and controller types; no dependencies.
package sps_pkg;

	localparam int COL_W      = 10;
	localparam int ROW_W      = 10;
	localparam int WANT_W     = 8;
	localparam int SLICE_W    = 8;
	localparam int COEF_W     = 10;
	localparam int CNT_W      = 32;
	localparam int BLK_W      = 21;
	localparam int ACT_W      = 9;
	localparam int DIV_W      = 11;
	localparam int DVSR_W     = 10;
	localparam int PROD_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICES  = 2'd2;

	// Operation codes.
	localparam logic [1:0] OP_NOTE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_MAP  = 2'd2;

	// Block modes.
	localparam logic [1:0] MODE_SKIP  = 2'd0;
	localparam logic [1:0] MODE_INTRA = 2'd2;

	// Counter selection codes.
	localparam logic [2:0] CH_LUMA    = 3'd0;
	localparam logic [2:0] CH_CHROMA  = 3'd1;
	localparam logic [2:0] CH_SKIP    = 3'd2;
	localparam logic [2:0] CH_INTRA   = 3'd3;
	localparam logic [2:0] CH_INTER   = 3'd4;
	localparam logic [2:0] CH_NONZERO = 3'd5;
	localparam logic [2:0] CH_SUM     = 3'd6;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [SLICE_W-1:0] slice_index;
		logic [ROW_W-1:0]  row_number;
		logic              chroma_flag;
		logic [1:0]        block_mode;
		logic [COEF_W-1:0] coefficient_total;
		logic [2:0]        counter_choice;
	} item_t;

	typedef struct packed {
		logic               ok;
		logic [SLICE_W-1:0] slice_number;
		logic [ROW_W-1:0]   first_row;
		logic [ROW_W-1:0]   row_total;
		logic [BLK_W-1:0]   block_total;
		logic [BLK_W-1:0]   start_block;
		logic [BLK_W-1:0]   end_block;
		logic [CNT_W-1:0]   counter_value;
	} result_t;

	// One memory row: all seven statistics of one slice.
	typedef struct packed {
		logic [CNT_W-1:0] luma;
		logic [CNT_W-1:0] chroma;
		logic [CNT_W-1:0] skip;
		logic [CNT_W-1:0] intra;
		logic [CNT_W-1:0] inter;
		logic [CNT_W-1:0] nonzero;
		logic [CNT_W-1:0] coef_sum;
	} counters_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_PLAN,
		ST_PLAN_WAIT,
		ST_MAP_WAIT,
		ST_MEM_RD,
		ST_MEM_WR,
		ST_GEO_FIRST,
		ST_GEO_START,
		ST_GEO_BLOCK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic cfg_write;
		logic clear_stats;
		logic load_item;
		logic div_start;
		logic div_plan;
		logic store_plan;
		logic slice_from_div;
		logic mem_rd;
		logic mem_wr;
		logic geo_first;
		logic geo_start;
		logic geo_block;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       slice_ok;
		logic       div_done;
	} status_t;

endpackage

>>> hw/rtl/sps_div.sv
// Restoring divider, one quotient bit per cycle, for the slice partition block.
// Depends on sps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sps_pkg::DIV_W-1:0]  dividend,
	input  logic [sps_pkg::DVSR_W-1:0] divisor,
	output logic                       done,
	output logic [sps_pkg::DIV_W-1:0]  quotient
);
	import sps_pkg::*;

	localparam int STEP_W = $clog2(DIV_W + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [DVSR_W-1:0]   rem_q;
	logic [DVSR_W-1:0]   dvsr_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DVSR_W:0]     trial;
	logic                fits;

	// The dividend shifts out of quo_q from the top while quotient bits enter below.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvsr_q <= divisor;
			quo_q  <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVSR_W'(trial - {1'b0, dvsr_q});
			end else begin
				rem_q <= trial[DVSR_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`SPS_ASSERT_NOW(a_div_done_idle, done_q, !busy_q, "divider reports done while still busy")
	`SPS_ASSERT_NEXT(a_div_start_busy, start, busy_q, "divider did not start")

endmodule

>>> hw/rtl/sps_ctrl.sv
// Controller state machine of the slice partition block.
// Depends on sps_pkg and assert_macros.svh; drives the datapath through cmd_t.
`include "assert_macros.svh"

module sps_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
	output logic                          result_valid,
	input  logic                          result_stall,
	input  sps_pkg::status_t              status,
	output sps_pkg::cmd_t                 cmd
);
	import sps_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;
	logic   out_free;
	logic   cfg_acc;
	logic   cfg_hit;

	assign out_free   = !result_valid_q || !result_stall;
	assign cfg_ready  = state_q == ST_IDLE;
	assign item_stall = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign cfg_hit    = cfg_acc && (cfg_index == REG_COLUMNS || cfg_index == REG_ROWS ||
		cfg_index == REG_SLICES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cfg_acc) begin
					cmd.cfg_write   = 1'b1;
					cmd.clear_stats = cfg_hit;
					if (cfg_hit) begin
						state_d = ST_PLAN;
					end
				end else if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DISPATCH;
				end
			end
			ST_PLAN: begin
				cmd.div_start = 1'b1;
				cmd.div_plan  = 1'b1;
				state_d       = ST_PLAN_WAIT;
			end
			ST_PLAN_WAIT: begin
				if (status.div_done) begin
					cmd.store_plan = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_DISPATCH: begin
				case (status.opcode)
					OP_NOTE, OP_READ: begin
						state_d = status.slice_ok ? ST_MEM_RD : ST_FINISH;
					end
					OP_MAP: begin
						cmd.div_start = 1'b1;
						state_d       = ST_MAP_WAIT;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_MAP_WAIT: begin
				if (status.div_done) begin
					cmd.slice_from_div = 1'b1;
					state_d            = ST_GEO_FIRST;
				end
			end
			ST_MEM_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = (status.opcode == OP_NOTE) ? ST_MEM_WR : ST_GEO_FIRST;
			end
			ST_MEM_WR: begin
				cmd.mem_wr = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_GEO_FIRST: begin
				cmd.geo_first = 1'b1;
				state_d       = ST_GEO_START;
			end
			ST_GEO_START: begin
				cmd.geo_start = 1'b1;
				state_d       = ST_GEO_BLOCK;
			end
			ST_GEO_BLOCK: begin
				cmd.geo_block = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = result_valid_q;

	`SPS_ASSERT_NEXT(a_busy_after_item, item_valid && !item_stall, item_stall,
		"input taken while a transaction is still in work")
	`SPS_ASSERT_NEXT(a_plan_after_cfg, cfg_hit, state_q == ST_PLAN,
		"register write did not start a plan update")
	`SPS_ASSERT_NEXT(a_result_loaded, state_q == ST_FINISH && out_free, result_valid_q,
		"finished transaction produced no result")

endmodule

>>> hw/rtl/sps_dpath.sv
// Datapath of the slice partition block: registers, plan, statistics memory,
// shared divider and multiplier, result register. Depends on sps_pkg and sps_div.
module sps_dpath #(
	parameter int MAX_SLICES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sps_pkg::cmd_t                  cmd,
	output sps_pkg::status_t               status,
	input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  sps_pkg::item_t                 item,
	output sps_pkg::result_t               result
);
	import sps_pkg::*;

	localparam int AW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam logic [ROW_W-1:0] MAX_ROWS = ROW_W'(MAX_SLICES);

	// Configuration and plan.
	logic [COL_W-1:0]  cols_q;
	logic [ROW_W-1:0]  rows_q;
	logic [WANT_W-1:0] want_q;
	logic [ACT_W-1:0]  active_q;
	logic [ROW_W-1:0]  re_q;
	logic [ROW_W-1:0]  want_n;
	logic [ROW_W-1:0]  plan_n;

	// Item and geometry.
	item_t              item_q;
	logic [SLICE_W-1:0] slice_q;
	logic [ROW_W-1:0]   first_q;
	logic [ROW_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  start_q;
	logic [PROD_W-1:0]  blk_q;
	logic [ROW_W-1:0]   rest_rows;
	logic [ROW_W-1:0]   mul_a;
	logic [ROW_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod;

	// Divider.
	logic [DIV_W-1:0]  div_dividend;
	logic [DVSR_W-1:0] div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [SLICE_W-1:0] map_slice;

	// Statistics memory.
	counters_t               mem [MAX_SLICES];
	logic [MAX_SLICES-1:0]   row_vld_q;
	counters_t               rd_row_q;
	logic                    rd_vld_q;
	counters_t               cur;
	counters_t               upd;
	logic [AW-1:0]           addr;
	logic                    slice_ok;

	result_t                 res_d;
	result_t                 result_q;
	logic [CNT_W-1:0]        sel_cnt;

	// Slice count clamp: zero means one, then at most rows and at most MAX_SLICES; one if rows is zero.
	always_comb begin
		want_n = (want_q == '0) ? ROW_W'(1) : ROW_W'(want_q);
		plan_n = want_n;
		if (plan_n > rows_q) begin
			plan_n = rows_q;
		end
		if (plan_n > MAX_ROWS) begin
			plan_n = MAX_ROWS;
		end
		if (rows_q == '0) begin
			plan_n = ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= '0;
			rows_q   <= '0;
			want_q   <= WANT_W'(1);
			active_q <= ACT_W'(1);
			re_q     <= ROW_W'(1);
		end else begin
			if (cmd.cfg_write) begin
				case (cfg_index)
					REG_COLUMNS: cols_q <= cfg_data[COL_W-1:0];
					REG_ROWS:    rows_q <= cfg_data[ROW_W-1:0];
					REG_SLICES:  want_q <= cfg_data[WANT_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.store_plan) begin
				active_q <= ACT_W'(plan_n);
				re_q     <= (div_quo == '0) ? ROW_W'(1) : div_quo[ROW_W-1:0];
			end
		end
	end

	// Ceiling division for the plan, plain division for row mapping.
	assign div_dividend = cmd.div_plan ?
		DIV_W'({1'b0, rows_q} + {1'b0, plan_n} - 1'b1) : DIV_W'(item_q.row_number);
	assign div_divisor  = cmd.div_plan ? plan_n : re_q;

	sps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign map_slice = (div_quo >= DIV_W'(active_q)) ?
		SLICE_W'(active_q - 1'b1) : div_quo[SLICE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
	end

	assign slice_ok = {1'b0, item_q.slice_index} < active_q;
	assign addr     = item_q.slice_index[AW-1:0];

	assign status.opcode   = item_q.opcode;
	assign status.slice_ok = slice_ok;
	assign status.div_done = div_done;

	// Shared multiplier; the operands follow the geometry step.
	always_comb begin
		mul_a = first_q;
		mul_b = cols_q;
		if (cmd.geo_first) begin
			mul_a = ROW_W'(slice_q);
			mul_b = re_q;
		end else if (cmd.geo_block) begin
			mul_a = cnt_q;
		end
	end

	assign prod      = mul_a * mul_b;
	assign rest_rows = rows_q - first_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			slice_q <= item.slice_index;
		end else if (cmd.slice_from_div) begin
			slice_q <= map_slice;
		end
		if (cmd.geo_first) begin
			first_q <= (prod > PROD_W'(rows_q)) ? rows_q : prod[ROW_W-1:0];
		end
		if (cmd.geo_start) begin
			start_q <= prod;
			cnt_q   <= (rest_rows > re_q) ? re_q : rest_rows;
		end
		if (cmd.geo_block) begin
			blk_q <= prod;
		end
	end

	// Statistics memory, read-modify-write through the registered read row rd_row_q.
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_row_q <= mem[addr];
		end
		if (cmd.mem_wr) begin
			mem[addr] <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.mem_rd) begin
				rd_vld_q <= row_vld_q[addr];
			end
			if (cmd.clear_stats) begin
				row_vld_q <= '0;
			end else if (cmd.mem_wr) begin
				row_vld_q[addr] <= 1'b1;
			end
		end
	end

	assign cur = rd_vld_q ? rd_row_q : '0;

	always_comb begin
		upd = cur;
		if (item_q.chroma_flag) begin
			upd.chroma = cur.chroma + 1'b1;
		end else begin
			upd.luma = cur.luma + 1'b1;
		end
		case (item_q.block_mode)
			MODE_SKIP:  upd.skip  = cur.skip + 1'b1;
			MODE_INTRA: upd.intra = cur.intra + 1'b1;
			default:    upd.inter = cur.inter + 1'b1;
		endcase
		if (item_q.coefficient_total != '0) begin
			upd.nonzero  = cur.nonzero + 1'b1;
			upd.coef_sum = cur.coef_sum + CNT_W'(item_q.coefficient_total);
		end
	end

	always_comb begin
		case (item_q.counter_choice)
			CH_LUMA:    sel_cnt = cur.luma;
			CH_CHROMA:  sel_cnt = cur.chroma;
			CH_SKIP:    sel_cnt = cur.skip;
			CH_INTRA:   sel_cnt = cur.intra;
			CH_INTER:   sel_cnt = cur.inter;
			CH_NONZERO: sel_cnt = cur.nonzero;
			CH_SUM:     sel_cnt = cur.coef_sum;
			default:    sel_cnt = '0;
		endcase
	end

	// Result assembly.
	always_comb begin
		res_d = '0;
		case (item_q.opcode)
			OP_NOTE: begin
				res_d.ok           = slice_ok;
				res_d.slice_number = item_q.slice_index;
			end
			OP_READ: begin
				res_d.ok           = slice_ok;
				res_d.slice_number = item_q.slice_index;
				if (slice_ok) begin
					res_d.first_row     = first_q;
					res_d.row_total     = cnt_q;
					res_d.block_total   = BLK_W'(blk_q);
					res_d.start_block   = BLK_W'(start_q);
					res_d.end_block     = BLK_W'(start_q) + BLK_W'(blk_q);
					res_d.counter_value = sel_cnt;
				end
			end
			OP_MAP: begin
				res_d.ok           = 1'b1;
				res_d.slice_number = slice_q;
				res_d.first_row    = first_q;
				res_d.row_total    = cnt_q;
				res_d.block_total  = BLK_W'(blk_q);
				res_d.start_block  = BLK_W'(start_q);
				res_d.end_block    = BLK_W'(start_q) + BLK_W'(blk_q);
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			result_q <= res_d;
		end
	end

	assign result = result_q;

endmodule

>>> hw/rtl/slice_partition_and_block_stats.sv
// Top level of the slice partition and block statistics block.
// Depends on sps_pkg, sps_ctrl and sps_dpath.

// A frame of macroblock rows is divided into slices of equal height (the last
// slices may be shorter or empty), and each slice keeps seven 32-bit wrapping
// statistics counters. Each input transaction carries one operation: note a
// block into a slice, read a slice's geometry together with one selected
// counter, or map a macroblock row to its slice; every transaction returns
// exactly one result transaction. Writing any of the three known registers
// (columns, rows, wanted slice count) recomputes the slice plan and clears all
// counters; a write to an unknown index is taken and ignored. The plan update
// runs the shared 11-step divider, during which the input is stalled. A note or
// read on a valid slice starts with a read of the statistics memory; a note then
// writes the row back, and a read runs three steps of the shared multiplier. A row
// mapping runs the divider, one quotient bit per cycle, and then those three steps.
// One transaction is in work at a time; a finished result sits in an output
// register, so the next transaction is accepted while the previous result is
// still stalled, and work only waits when a second result is ready to leave.
// Counter clearing is immediate through one valid bit per slice.
module slice_partition_and_block_stats #(
	parameter int MAX_SLICES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  sps_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output sps_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sps_pkg::*;

	// The controller sequences each transaction; the datapath holds all state.
	cmd_t    cmd;
	status_t status;

	sps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	sps_dpath #(
		.MAX_SLICES (MAX_SLICES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.result    (result)
	);

endmodule
